>>> rtl/bar_pkg.sv
// shared types, constants and aes helper functions for the address resolver
package bar_pkg;

   localparam int unsigned AddrWidth  = 48;
   localparam int unsigned KeyWidth   = 128;
   localparam int unsigned AesRounds  = 10;
   localparam int unsigned ReqBytes   = 23;
   localparam int unsigned RspBytes   = 1;

   localparam logic [7:0] StaticMask = 8'hc0;

   localparam logic [1:0] CLASS_PUBLIC     = 2'd0;
   localparam logic [1:0] CLASS_STATIC     = 2'd1;
   localparam logic [1:0] CLASS_RESOLVED   = 2'd2;
   localparam logic [1:0] CLASS_UNRESOLVED = 2'd3;

   localparam logic [1:0] TYPE_PUBLIC    = 2'd0;
   localparam logic [1:0] TYPE_RANDOM    = 2'd1;
   localparam logic [1:0] TYPE_PUBLIC_ID = 2'd2;
   localparam logic [1:0] TYPE_RANDOM_ID = 2'd3;

   // data carried from one round cell to the next
   typedef struct packed {
      logic         valid;
      logic [127:0] state;
      logic [127:0] round_key;
      logic [7:0]   rcon;
      logic [23:0]  hash;
      logic         need_hash;
      logic [1:0]   early_class;
   } cell_type;

   function automatic logic [7:0] sbox(input logic [7:0] v);
      logic [7:0] r;
      case (v)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   // byte n of the aes state (byte 0 first) sits in bits 127-8n -: 8
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
      return s[127 - 8 * n -: 8];
   endfunction

endpackage

>>> rtl/bar_round_cell.sv
// one aes round with on-the-fly key expansion, registered toward the next cell
module bar_round_cell #(
   parameter bit LastRound = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  bar_pkg::cell_type cell_in,
   output bar_pkg::cell_type cell_out
);

   bar_pkg::cell_type cell_ff, cell_in_next;
   logic [127:0] shifted, mixed, next_key;
   logic [31:0]  rot_word;
   logic [7:0]   a0, a1, a2, a3, all;

   always_comb begin
      // sub bytes and shift rows
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) begin
            shifted[127 - 8 * (j + 4 * c) -: 8] =
               bar_pkg::sbox(bar_pkg::get_byte(cell_in.state, j + 4 * ((c + j) % 4)));
         end
      end
      mixed = shifted;
      a0 = 8'h00; a1 = 8'h00; a2 = 8'h00; a3 = 8'h00; all = 8'h00;
      if (!LastRound) begin
         for (int c = 0; c < 4; c++) begin
            a0  = bar_pkg::get_byte(shifted, 4 * c);
            a1  = bar_pkg::get_byte(shifted, 4 * c + 1);
            a2  = bar_pkg::get_byte(shifted, 4 * c + 2);
            a3  = bar_pkg::get_byte(shifted, 4 * c + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32 * c -: 32] = {a0 ^ all ^ bar_pkg::xtime(a0 ^ a1),
                                         a1 ^ all ^ bar_pkg::xtime(a1 ^ a2),
                                         a2 ^ all ^ bar_pkg::xtime(a2 ^ a3),
                                         a3 ^ all ^ bar_pkg::xtime(a3 ^ a0)};
         end
      end
      // next round key from the last word of the current one
      rot_word = {bar_pkg::sbox(cell_in.round_key[23:16]) ^ cell_in.rcon,
                  bar_pkg::sbox(cell_in.round_key[15:8]),
                  bar_pkg::sbox(cell_in.round_key[7:0]),
                  bar_pkg::sbox(cell_in.round_key[31:24])};
      next_key[127:96] = cell_in.round_key[127:96] ^ rot_word;
      next_key[95:64]  = cell_in.round_key[95:64] ^ next_key[127:96];
      next_key[63:32]  = cell_in.round_key[63:32] ^ next_key[95:64];
      next_key[31:0]   = cell_in.round_key[31:0] ^ next_key[63:32];

      cell_in_next           = cell_in;
      cell_in_next.state     = mixed ^ next_key;
      cell_in_next.round_key = next_key;
      cell_in_next.rcon      = bar_pkg::xtime(cell_in.rcon);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (advance) begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule

>>> rtl/ble_address_resolver.sv
// top level: address classifier with a ten-cell aes-128 round pipeline
//
// requests come in on req_ (tdata = address, addr_type, key_high, key_low
// from the lowest bit up) and one class per request leaves on rsp_.
// public and public identity types give public; random types with both top
// address bits set give random static; other random addresses are hashed
// with aes-128 under the request's key and the low 24 bits compared.
// every request, whatever its type, travels through the same chain of one
// input register and ten round cells, one aes round per cell, then one
// output register. throughput is one request per cycle while the receiver
// does not stall, set by the round cells, which all advance together.
// when the receiver stalls with the output register full, the whole chain
// holds and req_tready drops; req_tready follows the output register only,
// so it drops even while bubbles sit further up the chain.
// reset clears all valid bits; the chain then holds nothing and
// req_tready is high.
module ble_address_resolver (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // address[47:0], addr_type[49:48], key_high[113:50], key_low[177:114]
   input  logic [183:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // addr_class[1:0]
   output logic [7:0]   rsp_tdata
);

   localparam int unsigned Rounds = bar_pkg::AesRounds;

   bar_pkg::cell_type chain [Rounds + 1];
   bar_pkg::cell_type head_ff, head_in;
   logic       rsp_valid_ff;
   logic [1:0] rsp_class_ff, rsp_class_in;
   logic       advance;
   logic [47:0] req_address;
   logic [1:0]  req_addr_type;
   logic [127:0] req_key;
   logic [127:0] block;

   assign req_address   = req_tdata[47:0];
   assign req_addr_type = req_tdata[49:48];
   assign req_key       = {req_tdata[113:50], req_tdata[177:114]};

   // chain moves unless the output register is full and stalled
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      block = {104'd0, req_address[47:24]};
      head_in           = '0;
      head_in.valid     = req_tvalid;
      head_in.state     = block ^ req_key;
      head_in.round_key = req_key;
      head_in.rcon      = 8'h01;
      head_in.hash      = req_address[23:0];
      head_in.need_hash = 1'b0;
      if (req_addr_type inside {bar_pkg::TYPE_PUBLIC, bar_pkg::TYPE_PUBLIC_ID}) begin
         head_in.early_class = bar_pkg::CLASS_PUBLIC;
      end else if ((req_address[47:40] & bar_pkg::StaticMask) == bar_pkg::StaticMask) begin
         head_in.early_class = bar_pkg::CLASS_STATIC;
      end else begin
         head_in.early_class = bar_pkg::CLASS_UNRESOLVED;
         head_in.need_hash   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else if (advance) begin
         head_ff <= head_in;
      end
   end

   assign chain[0] = head_ff;

   for (genvar g = 0; g < Rounds; g++) begin : g_round
      bar_round_cell #(
         .LastRound(g == Rounds - 1)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_in (chain[g]),
         .cell_out(chain[g + 1])
      );
   end

   always_comb begin
      rsp_class_in = chain[Rounds].early_class;
      if (chain[Rounds].need_hash && chain[Rounds].state[23:0] == chain[Rounds].hash) begin
         rsp_class_in = bar_pkg::CLASS_RESOLVED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain[Rounds].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_class_ff <= rsp_class_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_class_ff};

   // a stalled response keeps its class
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("response changed under stall");

   // a request that skips the hash never carries the unresolved class
   assert property (@(posedge clock) disable iff (reset)
      head_ff.valid && !head_ff.need_hash && advance
         |-> head_ff.early_class != bar_pkg::CLASS_UNRESOLVED)
      else $error("non-hashed request marked unresolved");

   // ready follows the output stage only
   assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready out of step with output stage");

endmodule
